@@ design/kuwahara_range_smoothing_filter_assert.svh @@
// Assertion macros used by the filter's top module.
`ifndef KUWAHARA_RANGE_SMOOTHING_FILTER_ASSERT_SVH
`define KUWAHARA_RANGE_SMOOTHING_FILTER_ASSERT_SVH

// A condition implies a consequence in the same cycle.
`define KRSF_ASSERT_IMPLY(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// A condition implies a consequence in the next cycle.
`define KRSF_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

@@ design/krsf_pkg.sv @@
`timescale 1ns / 1ps
package krsf_pkg;
   localparam int MaxWidth     = 1024;
   localparam int MaxHalf      = 8;
   localparam int LineDepth    = 16384;
   localparam int PixW         = 24;
   localparam int CfgIdxW      = 2;
   localparam int CfgDataW     = 16;
   localparam logic [CfgIdxW-1:0] RegWidth  = 2'd0;
   localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;
   localparam logic [CfgIdxW-1:0] RegWindow = 2'd2;
   localparam logic [10:0] ResetWidth  = 11'd640;
   localparam logic [15:0] ResetHeight = 16'd480;
   localparam logic [4:0]  ResetWindow = 5'd4;
   localparam logic InKindPixel = 1'b0;
   localparam logic InKindDrain = 1'b1;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // Start request to the window engine.
   typedef struct packed {
      logic        start;
      logic [15:0] x;
      logic [15:0] y;
      logic        last;
   } job_type;

   typedef struct packed {
      logic       done;
      pixel_type  pix;
      logic       last;
   } res_type;
endpackage

@@ design/kuwahara_range_smoothing_filter.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Beat contents
// req     | in        | tdata: in_red, in_green, in_blue; tuser: kind
// rsp     | out       | tdata: out_red, out_green, out_blue; tlast: frame_end
// csr     | in        | index 0 width, 1 height, 2 window size
// An input beat that releases an output ties up the block while the window
// engine makes one line-store read per window position and then runs three
// serial divisions. Other beats do not tie it up.
// Reset is synchronous; the line store is not cleared. The output register
// holds a result while rsp_tready is low; new work then waits.
module kuwahara_range_smoothing_filter #(
   parameter int MAX_WIDTH  = krsf_pkg::MaxWidth,
   parameter int MAX_HALF   = krsf_pkg::MaxHalf,
   parameter int LINE_DEPTH = krsf_pkg::LineDepth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata, // in_red, in_green, in_blue
   input  logic                          req_tuser, // kind
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [23:0]                   rsp_tdata, // out_red, out_green, out_blue
   output logic                          rsp_tlast,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [krsf_pkg::CfgIdxW-1:0]  csr_index,
   input  logic [krsf_pkg::CfgDataW-1:0] csr_data
);
   import krsf_pkg::*;
   `include "kuwahara_range_smoothing_filter_assert.svh"
   localparam int WW = $clog2(MAX_WIDTH+1);
   localparam int HW = $clog2(MAX_HALF+1);
   localparam int AW = $clog2(LINE_DEPTH);

   logic [10:0] width_ff;
   logic [15:0] height_ff;
   logic [4:0]  window_ff;
   logic [15:0] in_col_ff, in_row_ff, out_col_ff, out_row_ff;
   logic        busy_ff;
   logic        out_v_ff;
   pixel_type   out_d_ff;
   logic        out_l_ff;
   job_type     job;
   res_type     res;
   logic [WW-1:0] eff_w;
   logic [15:0]   eff_h;
   logic [HW-1:0] eff_half;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [PixW-1:0] rd_data;
   logic [31:0]   delay, in_cnt_nx, out_idx, wl;
   logic [15:0]   nc, nr;
   logic          acc, is_pix, wr_en, emit, last_o;
   logic [4:0]    hraw;

   always_comb begin
      eff_w = (width_ff == 11'd0) ? WW'(1)
            : ({21'b0, width_ff} > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(width_ff);
      eff_h = (height_ff == 16'd0) ? 16'd1 : height_ff;
      hraw  = {1'b0, window_ff[4:1]};
      eff_half = (hraw == 5'd0) ? HW'(1)
               : ({27'b0, hraw} > 32'(MAX_HALF)) ? HW'(MAX_HALF) : HW'(hraw);
      acc    = req_tvalid && req_tready;
      is_pix = req_tuser == InKindPixel;
      wr_en  = acc && is_pix && (in_row_ff < eff_h);
      wl     = in_row_ff * {{(16-WW){1'b0}}, eff_w} + {16'b0, in_col_ff};
      wr_addr = wl[AW-1:0];
      nc = in_col_ff + 16'd1; nr = in_row_ff;
      if (nc >= {{(16-WW){1'b0}}, eff_w}) begin nc = 16'd0; nr = in_row_ff + 16'd1; end
      in_cnt_nx = nr * {{(16-WW){1'b0}}, eff_w} + {16'b0, nc};
      out_idx   = out_row_ff * {{(16-WW){1'b0}}, eff_w} + {16'b0, out_col_ff};
      delay     = (32'(eff_half) - 32'd1) * (32'(eff_w) + 32'd1);
      last_o    = (out_row_ff == eff_h - 16'd1)
                  && (out_col_ff == {{(16-WW){1'b0}}, eff_w} - 16'd1);
      if (acc && is_pix)
         emit = wr_en && (in_cnt_nx > out_idx) && (in_cnt_nx - out_idx > delay);
      else
         emit = acc && (in_row_ff >= eff_h) && (out_row_ff < eff_h);
      job.start = emit;
      job.x = out_col_ff; job.y = out_row_ff; job.last = last_o;
   end

   assign req_tready = !busy_ff && !out_v_ff && !csr_valid;
   assign csr_ready  = !busy_ff && !out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= ResetWidth; height_ff <= ResetHeight; window_ff <= ResetWindow;
         in_col_ff <= '0; in_row_ff <= '0; out_col_ff <= '0; out_row_ff <= '0;
         busy_ff <= 1'b0; out_v_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               RegWidth:  width_ff  <= csr_data[10:0];
               RegHeight: height_ff <= csr_data;
               RegWindow: window_ff <= csr_data[4:0];
               default: ;
            endcase
            if (csr_index == RegWidth || csr_index == RegHeight || csr_index == RegWindow) begin
               in_col_ff <= '0; in_row_ff <= '0; out_col_ff <= '0; out_row_ff <= '0;
            end
         end else begin
            // The frame's last output clears the input position instead.
            if (wr_en && !(emit && last_o)) begin in_col_ff <= nc; in_row_ff <= nr; end
            if (emit) begin
               busy_ff <= 1'b1;
               if (last_o) begin
                  in_col_ff <= '0; in_row_ff <= '0; out_col_ff <= '0; out_row_ff <= '0;
               end else if (out_col_ff + 16'd1 >= {{(16-WW){1'b0}}, eff_w}) begin
                  out_col_ff <= '0; out_row_ff <= out_row_ff + 16'd1;
               end else begin
                  out_col_ff <= out_col_ff + 16'd1;
               end
            end
         end
         if (res.done) begin
            busy_ff  <= 1'b0;
            out_v_ff <= 1'b1;
            out_d_ff <= res.pix;
            out_l_ff <= res.last;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   krsf_ram #(.Width(PixW), .Depth(LINE_DEPTH)) u_store (
      .clock (clock), .wr_en (wr_en), .wr_addr (wr_addr),
      .wr_data ({req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]}),
      .rd_addr (rd_addr), .rd_data (rd_data)
   );

   krsf_window #(.MAX_WIDTH(MAX_WIDTH), .MAX_HALF(MAX_HALF), .LINE_DEPTH(LINE_DEPTH)) u_win (
      .clock (clock), .reset (reset), .job (job), .eff_w (eff_w), .eff_h (eff_h),
      .eff_half (eff_half), .rd_addr (rd_addr), .rd_data (rd_data), .res (res)
   );

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_d_ff.blue, out_d_ff.green, out_d_ff.red};
   assign rsp_tlast  = out_l_ff;

   `KRSF_ASSERT_IMPLY(a_no_write_busy, clock, reset, busy_ff, !wr_en, "store written while busy")
   `KRSF_ASSERT_NEXT(a_job_busy, clock, reset, job.start, busy_ff, "job start did not mark busy")
   `KRSF_ASSERT_IMPLY(a_done_when_busy, clock, reset, res.done, busy_ff && !out_v_ff,
      "result without pending job")
endmodule

@@ design/krsf_ram.sv @@
`timescale 1ns / 1ps
module krsf_ram #(
   parameter int Width = 24,
   parameter int Depth = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ design/krsf_divider.sv @@
`timescale 1ns / 1ps
// Restoring divider: one quotient bit per cycle. The quotient is known to fit in 8 bits.
module krsf_divider #(
   parameter int DividendW = 15,
   parameter int DivisorW  = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DividendW-1:0] dividend,
   input  logic [DivisorW-1:0]  divisor,
   output logic                 done,
   output logic [7:0]           quotient
);
   import krsf_pkg::*;
   localparam int CntW = $clog2(DividendW);

   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic [DividendW-1:0] quo_ff, quo_in;
   logic [DivisorW-1:0]  rem_ff, rem_in;
   logic [DivisorW-1:0]  dsr_ff, dsr_in;
   logic [DivisorW:0]    trial;
   logic [DivisorW:0]    diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[DividendW-1]};
      diff    = trial - {1'b0, dsr_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[DivisorW-1:0];
            quo_in = {quo_ff[DividendW-2:0], 1'b1};
         end else begin
            rem_in = trial[DivisorW-1:0];
            quo_in = {quo_ff[DividendW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CntW'(1);
         if (cnt_ff == CntW'(DividendW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[7:0];
endmodule

@@ design/krsf_window.sv @@
`timescale 1ns / 1ps
// Walks the four quadrants of one output pixel through the line store,
// one read a cycle, then picks the winner and divides its sums.
module krsf_window #(
   parameter int MAX_WIDTH = krsf_pkg::MaxWidth,
   parameter int MAX_HALF  = krsf_pkg::MaxHalf,
   parameter int LINE_DEPTH = krsf_pkg::LineDepth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  krsf_pkg::job_type             job,
   input  logic [$clog2(MAX_WIDTH+1)-1:0] eff_w,
   input  logic [15:0]                   eff_h,
   input  logic [$clog2(MAX_HALF+1)-1:0] eff_half,
   output logic [$clog2(LINE_DEPTH)-1:0] rd_addr,
   input  logic [krsf_pkg::PixW-1:0]     rd_data,
   output krsf_pkg::res_type             res
);
   import krsf_pkg::*;
   localparam int HW = $clog2(MAX_HALF+1);
   localparam int AW = $clog2(LINE_DEPTH);
   localparam int CW = $clog2(MAX_HALF*MAX_HALF+1);
   localparam int SW = 8 + CW;

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_PICK, S_DIV, S_WAIT} state_type;
   state_type state_ff;

   logic [1:0]    q_ff;
   logic [HW-1:0] dx_ff, dy_ff;
   logic          last_ff;
   logic [15:0]   x_ff, y_ff;
   logic          rd_v_ff;
   logic [1:0]    rq_ff;
   logic [SW-1:0] sum_ff [4][3];
   logic [7:0]    mx_ff [4][3], mn_ff [4][3];
   logic [CW-1:0] cnt_ff [4];
   logic [1:0]    best_ff;
   logic [1:0]    ch_ff;
   logic [7:0]    qv_ff [3];
   logic          dstart_ff;
   logic          ddone;
   logic [7:0]    dquo;

   logic signed [17:0] px, py;
   logic               inside_img;
   logic [31:0]        lin;
   logic [9:0]         spread [4];

   always_comb begin
      px = $signed({2'b0, x_ff}) + $signed({{(18-HW){1'b0}}, dx_ff});
      py = $signed({2'b0, y_ff}) + $signed({{(18-HW){1'b0}}, dy_ff});
      if (!q_ff[0]) px = px - $signed({{(18-HW){1'b0}}, eff_half});
      if (!q_ff[1]) py = py - $signed({{(18-HW){1'b0}}, eff_half});
      inside_img = (px >= 0) && (px < $signed({{(18-$bits(eff_w)){1'b0}}, eff_w}))
                   && (py >= 0) && (py < $signed({2'b0, eff_h}));
      lin = py[15:0] * {{(16-$bits(eff_w)){1'b0}}, eff_w} + {16'b0, px[15:0]};
      rd_addr = lin[AW-1:0];
      for (int q = 0; q < 4; q++) begin
         spread[q] = {2'b0, mx_ff[q][0] - mn_ff[q][0]} + {2'b0, mx_ff[q][1] - mn_ff[q][1]}
                     + {2'b0, mx_ff[q][2] - mn_ff[q][2]};
      end
   end

   krsf_divider #(.DividendW(SW), .DivisorW(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dstart_ff),
      .dividend (sum_ff[best_ff][ch_ff]),
      .divisor  (cnt_ff[best_ff]),
      .done     (ddone),
      .quotient (dquo)
   );

   always_ff @(posedge clock) begin
      logic [7:0] v;
      logic [1:0] bq;
      logic [9:0] bs;
      if (reset) begin
         state_ff  <= S_IDLE;
         rd_v_ff   <= 1'b0;
         dstart_ff <= 1'b0;
         res.done  <= 1'b0;
      end else begin
         res.done  <= 1'b0;
         dstart_ff <= 1'b0;
         rd_v_ff   <= 1'b0;
         // Accumulate the word read last cycle.
         if (rd_v_ff) begin
            for (int c = 0; c < 3; c++) begin
               v = rd_data[16-8*c +: 8];
               sum_ff[rq_ff][c] <= sum_ff[rq_ff][c] + SW'(v);
               if (v > mx_ff[rq_ff][c]) mx_ff[rq_ff][c] <= v;
               if (v < mn_ff[rq_ff][c]) mn_ff[rq_ff][c] <= v;
            end
            cnt_ff[rq_ff] <= cnt_ff[rq_ff] + CW'(1);
         end
         unique case (state_ff)
            S_IDLE: begin
               if (job.start) begin
                  x_ff <= job.x; y_ff <= job.y; last_ff <= job.last;
                  q_ff <= 2'd0; dx_ff <= '0; dy_ff <= '0;
                  for (int q = 0; q < 4; q++) begin
                     cnt_ff[q] <= '0;
                     for (int c = 0; c < 3; c++) begin
                        sum_ff[q][c] <= '0; mx_ff[q][c] <= 8'd0; mn_ff[q][c] <= 8'd255;
                     end
                  end
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               rd_v_ff <= inside_img;
               rq_ff   <= q_ff;
               if (dx_ff == eff_half - HW'(1)) begin
                  dx_ff <= '0;
                  if (dy_ff == eff_half - HW'(1)) begin
                     dy_ff <= '0;
                     if (q_ff == 2'd3) state_ff <= S_LAST;
                     q_ff <= q_ff + 2'd1;
                  end else begin
                     dy_ff <= dy_ff + HW'(1);
                  end
               end else begin
                  dx_ff <= dx_ff + HW'(1);
               end
            end
            S_LAST: state_ff <= S_PICK;
            S_PICK: begin
               bq = 2'd3; bs = 10'd1023;
               for (int q = 0; q < 4; q++) begin
                  if (cnt_ff[q] != '0 && spread[q] < bs) begin
                     bs = spread[q]; bq = 2'(q);
                  end
               end
               best_ff   <= bq;
               ch_ff     <= 2'd0;
               dstart_ff <= 1'b1;
               state_ff  <= S_DIV;
            end
            S_DIV: begin
               if (ddone) begin
                  qv_ff[ch_ff] <= dquo;
                  if (ch_ff == 2'd2) begin
                     state_ff <= S_WAIT;
                  end else begin
                     ch_ff     <= ch_ff + 2'd1;
                     dstart_ff <= 1'b1;
                  end
               end
            end
            S_WAIT: begin
               res.done  <= 1'b1;
               res.pix   <= '{red: qv_ff[0], green: qv_ff[1], blue: qv_ff[2]};
               res.last  <= last_ff;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
   import krsf_pkg::*;

   localparam int WatchdogLimit = 5000;
   localparam int SettleCycles  = 400;
   localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

   typedef struct {
      logic        kind;
      logic [23:0] data;
      bit          typed;
      logic [24:0] result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;  // in_red, in_green, in_blue
   logic req_tuser = 1'b0;       // kind
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;       // out_red, out_green, out_blue
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CfgIdxW-1:0] csr_index = '0;
   logic [CfgDataW-1:0] csr_data = '0;

   kuwahara_range_smoothing_filter i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the filter: registers, raster counters and line store.
   logic [10:0] sh_width = ResetWidth;
   logic [15:0] sh_height = ResetHeight;
   logic [4:0] sh_window = ResetWindow;
   int in_col = 0, in_row = 0, out_col = 0, out_row = 0;
   logic [23:0] line_mem [LineDepth];

   // Expected output beats: {frame_end, blue, green, red}.
   logic [24:0] pending_pixels [$];
   int mismatches = 0;
   int n_items = 0;
   bit quiet = 1'b0;
   int stall_left = 0;
   int idle_cycles = 0;

   function automatic int eff_width();
      return (sh_width < 1) ? 1 : (sh_width > MaxWidth) ? MaxWidth : int'(sh_width);
   endfunction

   function automatic int eff_height();
      return (sh_height < 1) ? 1 : int'(sh_height);
   endfunction

   function automatic int eff_half();
      int hv;
      hv = sh_window / 2;
      return (hv < 1) ? 1 : (hv > MaxHalf) ? MaxHalf : hv;
   endfunction

   function automatic logic [24:0] smooth_pixel(int x, int y, logic last);
      int w, ht, hh, x0, y0, best, best_spread, s;
      int sum [4][3];
      int mx [4][3];
      int mn [4][3];
      int cnt [4];
      logic [23:0] pix;
      logic [24:0] r;
      w = eff_width();
      ht = eff_height();
      hh = eff_half();
      best = 3;
      best_spread = 10000;
      for (int q = 0; q < 4; q++) begin
         x0 = q[0] ? x : x - hh;
         y0 = q[1] ? y : y - hh;
         cnt[q] = 0;
         for (int c = 0; c < 3; c++) begin
            sum[q][c] = 0;
            mx[q][c] = 0;
            mn[q][c] = 255;
         end
         for (int yy = y0; yy < y0 + hh; yy++) begin
            for (int xx = x0; xx < x0 + hh; xx++) begin
               if (yy >= 0 && yy < ht && xx >= 0 && xx < w) begin
                  pix = line_mem[(yy * w + xx) % LineDepth];
                  for (int c = 0; c < 3; c++) begin
                     sum[q][c] += pix[8*c +: 8];
                     if (pix[8*c +: 8] > mx[q][c]) mx[q][c] = pix[8*c +: 8];
                     if (pix[8*c +: 8] < mn[q][c]) mn[q][c] = pix[8*c +: 8];
                  end
                  cnt[q]++;
               end
            end
         end
      end
      for (int q = 0; q < 4; q++) begin
         if (cnt[q] != 0) begin
            s = (mx[q][0] - mn[q][0]) + (mx[q][1] - mn[q][1]) + (mx[q][2] - mn[q][2]);
            if (s < best_spread) begin
               best_spread = s;
               best = q;
            end
         end
      end
      for (int c = 0; c < 3; c++) r[8*c +: 8] = 8'(sum[best][c] / cnt[best]);
      r[24] = last;
      return r;
   endfunction

   function automatic void emit_pixel();
      logic last;
      last = (out_row == eff_height() - 1) && (out_col == eff_width() - 1);
      pending_pixels.push_back(smooth_pixel(out_col, out_row, last));
      if (last) begin
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end else begin
         out_col++;
         if (out_col >= eff_width()) begin
            out_col = 0;
            out_row++;
         end
      end
   endfunction

   function automatic void predict_beat(logic kind, logic [23:0] d);
      int w, ht, dl;
      w = eff_width();
      ht = eff_height();
      dl = (eff_half() - 1) * (w + 1);
      if (kind == InKindDrain) begin
         if (in_row >= ht && out_row < ht) emit_pixel();
      end else if (in_row < ht) begin
         line_mem[(in_row * w + in_col) % LineDepth] = d;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         if ((in_row * w + in_col) - (out_row * w + out_col) > dl) emit_pixel();
      end
   endfunction

   task automatic send_beat(logic kind, logic [23:0] d);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      predict_beat(kind, d);
      n_items++;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      // The block may still be filtering after the last beat came out.
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx <= RegWindow) begin
         case (idx)
            RegWidth: sh_width = val[10:0];
            RegHeight: sh_height = val;
            default: sh_window = val[4:0];
         endcase
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end
   endtask

   function automatic logic [23:0] random_pixel();
      logic [23:0] base;
      case ($urandom_range(0, 3))
         0: return 24'($urandom);
         1: return {$urandom_range(0, 1) ? 8'hff : 8'h00, $urandom_range(0, 1) ? 8'hff : 8'h00,
                    $urandom_range(0, 1) ? 8'hff : 8'h00};
         default: begin
            // Flat areas with small noise produce spread ties between quadrants.
            base = 24'h808080;
            for (int c = 0; c < 3; c++) base[8*c +: 8] = 8'($urandom_range(120, 123));
            return base;
         end
      endcase
   endfunction

   // One frame: pixels with occasional stray drains, then, unless aborted, drains until the frame closes.
   task automatic run_frame(int w, int h, int win, int abort_at);
      int n;
      write_reg(RegWidth, 16'(w));
      write_reg(RegHeight, 16'(h));
      write_reg(RegWindow, 16'(win));
      n = (abort_at > 0) ? abort_at : eff_width() * eff_height();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0) send_beat(InKindDrain, 24'($urandom));
         send_beat(InKindPixel, random_pixel());
      end
      if (abort_at == 0) begin
         if ($urandom_range(0, 3) == 0) send_beat(InKindPixel, 24'($urandom));
         while (in_row >= eff_height()) send_beat(InKindDrain, 24'($urandom));
         if ($urandom_range(0, 3) == 0) send_beat(InKindDrain, 24'($urandom));
      end
      req_tvalid <= 1'b0;
   endtask

   stim_row_type pass_through_rows [] = '{
      '{InKindDrain, 24'h000000, 1'b1, 25'h0},
      '{InKindPixel, 24'h000000, 1'b1, {1'b1, 24'h000000}},
      '{InKindPixel, 24'hffffff, 1'b1, {1'b1, 24'hffffff}},
      '{InKindPixel, 24'h0000ff, 1'b1, {1'b1, 24'h0000ff}},
      '{InKindPixel, 24'h00ff00, 1'b1, {1'b1, 24'h00ff00}},
      '{InKindPixel, 24'hff0000, 1'b1, {1'b1, 24'hff0000}},
      '{InKindDrain, 24'hffffff, 1'b1, 25'h0},
      '{InKindPixel, 24'h5a3c96, 1'b1, {1'b1, 24'h5a3c96}},
      '{InKindPixel, 24'ha5c369, 1'b0, 25'h0}
   };

   initial begin
      int w, h, win, abort_at;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // A 1x1 frame with a window of 2 passes every pixel straight through.
      write_reg(RegWidth, 16'd1);
      write_reg(RegHeight, 16'd1);
      write_reg(RegWindow, 16'd2);
      foreach (pass_through_rows[i]) begin
         send_beat(pass_through_rows[i].kind, pass_through_rows[i].data);
         if (pass_through_rows[i].typed && pass_through_rows[i].result[24])
            pending_pixels[$] = pass_through_rows[i].result;
      end
      req_tvalid <= 1'b0;
      write_reg(RegUnused, 16'hffff);
      run_frame(3, 2, 4, 0);
      run_frame(2047, 1, 2, 0);
      run_frame(5, 4, 31, 0);
      run_frame(4, 3, 17, 0);
      run_frame(0, 0, 0, 0);
      run_frame(6, 65535, 5, 10);
      run_frame(7, 3, 1, 0);
      while (n_items < 1400) begin
         if (n_items > 1200) quiet = 1'b1;
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
         h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
         win = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 17);
         abort_at = 0;
         if ($urandom_range(0, 9) == 0 && w * h > 1) abort_at = $urandom_range(1, w * h - 1);
         run_frame(w, h, win, abort_at);
      end
      quiet = 1'b1;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      logic [24:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected output beat: data %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_tdata[7:0] !== want[7:0] || rsp_tdata[15:8] !== want[15:8] ||
                rsp_tdata[23:16] !== want[23:16] || rsp_tlast !== want[24]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("output mismatch: r/g/b/last expected %h/%h/%h/%b got %h/%h/%h/%b",
                           want[7:0], want[15:8], want[23:16], want[24],
                           rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end
endmodule
